// File: sv/rxri_pkg.sv
// rxri_pkg: types, widths and register indexes of the ray / z-plane rectangle intersector.
// Used by every file in sv/. Depends on nothing.
package rxri_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // texture coordinate, 0 to 1.0 inclusive
   localparam int TEX_WIDTH = FRAC_BITS + 1;
   // t numerator magnitude and quotient magnitude
   localparam int NUM_W     = DATA_WIDTH + FRAC_BITS + 1;
   // partial remainder and divisor of a divider cell
   localparam int REM_W     = DATA_WIDTH + 1;
   localparam int PROD_W    = 2 * DATA_WIDTH;
   // unsaturated hit coordinate
   localparam int POS_W     = 2 * DATA_WIDTH - FRAC_BITS + 1;
   localparam int T_CELLS   = NUM_W;
   localparam int TEX_CELLS = TEX_WIDTH;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_WIDTH-1:0] FIX_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RECT_X_MIN = 3'd0,
      CSR_RECT_X_MAX = 3'd1,
      CSR_RECT_Y_MIN = 3'd2,
      CSR_RECT_Y_MAX = 3'd3,
      CSR_PLANE_Z    = 3'd4
   } csr_index_type;

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type ray_origin_x;
      word_type ray_origin_y;
      word_type ray_origin_z;
      word_type ray_dir_x;
      word_type ray_dir_y;
      word_type ray_dir_z;
      word_type t_lower;
      word_type t_upper;
   } req_type;

   typedef struct packed {
      logic                 is_hit;
      word_type             hit_t;
      word_type             hit_x;
      word_type             hit_y;
      word_type             hit_z;
      logic [TEX_WIDTH-1:0] tex_u;
      logic [TEX_WIDTH-1:0] tex_v;
      logic                 front_face;
   } rsp_type;

   // data handed from one divider cell to the next
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] div;
      logic [NUM_W-1:0] nq;
   } div_cell_type;

endpackage

// File: sv/rxri_div_cell.sv
// rxri_div_cell: one restoring division step with its stage register.
// Depends on rxri_pkg.
module rxri_div_cell (
   input  logic                   clock,
   input  logic                   adv,
   input  rxri_pkg::div_cell_type prev_stage,
   output rxri_pkg::div_cell_type next_stage
);

   logic [rxri_pkg::REM_W:0] trial;
   logic [rxri_pkg::REM_W:0] diff;
   logic                     take;
   rxri_pkg::div_cell_type   cell_in;
   rxri_pkg::div_cell_type   cell_ff;

   // shift in the next numerator bit and try to subtract the divisor
   assign trial = {prev_stage.rem, prev_stage.nq[rxri_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, prev_stage.div};
   assign take  = (trial >= {1'b0, prev_stage.div});

   always_comb begin
      cell_in.rem = take ? diff[rxri_pkg::REM_W-1:0] : trial[rxri_pkg::REM_W-1:0];
      cell_in.div = prev_stage.div;
      cell_in.nq  = {prev_stage.nq[rxri_pkg::NUM_W-2:0], take};
   end

   // advance with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign next_stage = cell_ff;

endmodule

// File: sv/rxri_out_skid.sv
// rxri_out_skid: output register plus one skid entry between pipeline and result channel.
// Depends on rxri_pkg.
module rxri_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              pipe_valid,
   input  rxri_pkg::rsp_type pipe_data,
   output logic              pipe_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rxri_pkg::rsp_type rsp_payload
);

   logic              out_vld_ff;
   logic              skid_vld_ff;
   rxri_pkg::rsp_type out_ff;
   rxri_pkg::rsp_type skid_ff;
   logic              pop;
   logic              free;

   assign pipe_ready = !skid_vld_ff;
   assign pop        = pipe_valid && pipe_ready;
   assign free       = !out_vld_ff || rsp_ready;

   // refill the output from the skid first, park a transfer in the skid when held
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (free) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            out_ff      <= skid_ff;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= pop;
            out_ff     <= pipe_data;
         end
      end else if (pop) begin
         skid_vld_ff <= 1'b1;
         skid_ff     <= pipe_data;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule

// File: sv/ray_xy_rectangle_intersect.sv
// ray_xy_rectangle_intersect: ray against an axis-aligned rectangle in a z plane, Q16.16.
// Depends on rxri_pkg, rxri_div_cell, rxri_out_skid.
//
//   channel  ports                               direction
//   request  req_valid req_ready req_payload     in, one ray per transfer
//   result   rsp_valid rsp_ready rsp_payload     out, one result per ray
//   csr      csr_we csr_index csr_wdata          in, write only
//
// One ray enters per cycle unless the skid entry is full. The path holds 49 cells of the t
// divider chain, 3 stages for window check, multiply and add, 17 cells of the u/v chains
// (the bounds check rides in the first of them), one assembly stage and the output register.
// Synchronous reset clears valid bits and loads the register defaults.
// A stalled result goes into one skid entry; the whole pipeline holds while it is full.
module ray_xy_rectangle_intersect (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rxri_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rxri_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_we,
   input  logic [rxri_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rxri_pkg::DATA_WIDTH-1:0]      csr_wdata
);

   localparam int DW = rxri_pkg::DATA_WIDTH;

   typedef struct packed {
      rxri_pkg::word_type ox;
      rxri_pkg::word_type oy;
      rxri_pkg::word_type dx;
      rxri_pkg::word_type dy;
      rxri_pkg::word_type t_lower;
      rxri_pkg::word_type t_upper;
      logic               q_neg;
      logic               dz_zero;
      logic               dz_neg;
   } t_side_type;

   typedef struct packed {
      rxri_pkg::word_type ox;
      rxri_pkg::word_type oy;
      rxri_pkg::word_type dx;
      rxri_pkg::word_type dy;
      rxri_pkg::word_type ts;
      logic               win;
      logic               dz_neg;
   } b_stage_type;

   typedef struct packed {
      rxri_pkg::word_type                 ox;
      rxri_pkg::word_type                 oy;
      logic signed [rxri_pkg::PROD_W-1:0] px;
      logic signed [rxri_pkg::PROD_W-1:0] py;
      rxri_pkg::word_type                 ts;
      logic                               win;
      logic                               dz_neg;
   } c_stage_type;

   typedef struct packed {
      logic signed [rxri_pkg::POS_W-1:0] x;
      logic signed [rxri_pkg::POS_W-1:0] y;
      rxri_pkg::word_type                ts;
      logic                              win;
      logic                              dz_neg;
   } d_stage_type;

   typedef struct packed {
      logic               hit;
      rxri_pkg::word_type ts;
      rxri_pkg::word_type x;
      rxri_pkg::word_type y;
      logic               zero_u;
      logic               zero_v;
      logic               dz_neg;
   } e_side_type;

   // configuration registers
   rxri_pkg::word_type rect_x_min_ff, rect_x_max_ff, rect_y_min_ff, rect_y_max_ff, plane_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_min_ff <= '0;
         rect_x_max_ff <= rxri_pkg::FIX_ONE;
         rect_y_min_ff <= '0;
         rect_y_max_ff <= rxri_pkg::FIX_ONE;
         plane_z_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rxri_pkg::CSR_RECT_X_MIN: rect_x_min_ff <= csr_wdata;
            rxri_pkg::CSR_RECT_X_MAX: rect_x_max_ff <= csr_wdata;
            rxri_pkg::CSR_RECT_Y_MIN: rect_y_min_ff <= csr_wdata;
            rxri_pkg::CSR_RECT_Y_MAX: rect_y_max_ff <= csr_wdata;
            rxri_pkg::CSR_PLANE_Z:    plane_z_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   assign req_ready = adv;

   // prepare t numerator and divisor magnitudes
   logic signed [DW:0]                  dz_diff;
   logic signed [rxri_pkg::NUM_W-1:0]   t_num;
   logic [rxri_pkg::NUM_W-1:0]          t_num_mag;
   logic [DW-1:0]                       dz_mag;
   rxri_pkg::div_cell_type              t_chain [rxri_pkg::T_CELLS+1];
   t_side_type                          t_side_in;

   assign dz_diff   = (DW+1)'(plane_z_ff) - (DW+1)'(req_payload.ray_origin_z);
   assign t_num     = {dz_diff, {rxri_pkg::FRAC_BITS{1'b0}}};
   assign t_num_mag = t_num[rxri_pkg::NUM_W-1] ? -t_num : t_num;
   assign dz_mag    = req_payload.ray_dir_z[DW-1] ? -req_payload.ray_dir_z
                                                  : req_payload.ray_dir_z;

   always_comb begin
      t_chain[0].rem    = '0;
      t_chain[0].div    = {1'b0, dz_mag};
      t_chain[0].nq     = t_num_mag;
      t_side_in.ox      = req_payload.ray_origin_x;
      t_side_in.oy      = req_payload.ray_origin_y;
      t_side_in.dx      = req_payload.ray_dir_x;
      t_side_in.dy      = req_payload.ray_dir_y;
      t_side_in.t_lower = req_payload.t_lower;
      t_side_in.t_upper = req_payload.t_upper;
      t_side_in.q_neg   = t_num[rxri_pkg::NUM_W-1] ^ req_payload.ray_dir_z[DW-1];
      t_side_in.dz_zero = (req_payload.ray_dir_z == '0);
      t_side_in.dz_neg  = req_payload.ray_dir_z[DW-1];
   end

   // t divider chain, one quotient bit per cell
   for (genvar i = 0; i < rxri_pkg::T_CELLS; i++) begin : g_t_cell
      rxri_div_cell u_cell (
         .clock      (clock),
         .adv        (adv),
         .prev_stage (t_chain[i]),
         .next_stage (t_chain[i+1])
      );
   end

   logic [rxri_pkg::T_CELLS-1:0] t_vld_ff;
   t_side_type                   t_side_ff [rxri_pkg::T_CELLS];

   // carry ray data alongside the divider cells
   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= '0;
      end else if (adv) begin
         t_vld_ff <= {t_vld_ff[rxri_pkg::T_CELLS-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_side_ff[0] <= t_side_in;
         for (int i = 1; i < rxri_pkg::T_CELLS; i++) begin
            t_side_ff[i] <= t_side_ff[i-1];
         end
      end
   end

   // sign the quotient and check the t window
   t_side_type                         t_last;
   logic signed [rxri_pkg::NUM_W:0]    t_q;
   b_stage_type                        b_in, b_ff;
   logic                               b_vld_ff;

   assign t_last = t_side_ff[rxri_pkg::T_CELLS-1];
   assign t_q    = t_last.q_neg ? -{1'b0, t_chain[rxri_pkg::T_CELLS].nq}
                                : {1'b0, t_chain[rxri_pkg::T_CELLS].nq};

   always_comb begin
      b_in.ox     = t_last.ox;
      b_in.oy     = t_last.oy;
      b_in.dx     = t_last.dx;
      b_in.dy     = t_last.dy;
      b_in.ts     = t_q[DW-1:0];
      b_in.win    = !t_last.dz_zero
                    && (t_q >= (rxri_pkg::NUM_W+1)'(t_last.t_lower))
                    && (t_q <= (rxri_pkg::NUM_W+1)'(t_last.t_upper));
      b_in.dz_neg = t_last.dz_neg;
   end

   // multiply direction by t
   c_stage_type c_in, c_ff;
   logic        c_vld_ff;

   always_comb begin
      c_in.ox     = b_ff.ox;
      c_in.oy     = b_ff.oy;
      c_in.px     = b_ff.dx * b_ff.ts;
      c_in.py     = b_ff.dy * b_ff.ts;
      c_in.ts     = b_ff.ts;
      c_in.win    = b_ff.win;
      c_in.dz_neg = b_ff.dz_neg;
   end

   // add the floored product to the origin
   d_stage_type d_in, d_ff;
   logic        d_vld_ff;

   always_comb begin
      d_in.x      = rxri_pkg::POS_W'(c_ff.ox) + rxri_pkg::POS_W'(c_ff.px >>> rxri_pkg::FRAC_BITS);
      d_in.y      = rxri_pkg::POS_W'(c_ff.oy) + rxri_pkg::POS_W'(c_ff.py >>> rxri_pkg::FRAC_BITS);
      d_in.ts     = c_ff.ts;
      d_in.win    = c_ff.win;
      d_in.dz_neg = c_ff.dz_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= t_vld_ff[rxri_pkg::T_CELLS-1];
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
      end
   end

   // bounds check and u/v divider setup
   logic signed [DW:0]     span_x, span_y;
   logic [DW-1:0]          off_x, off_y;
   rxri_pkg::div_cell_type u_chain [rxri_pkg::TEX_CELLS+1];
   rxri_pkg::div_cell_type v_chain [rxri_pkg::TEX_CELLS+1];
   e_side_type             e_side_in;

   assign span_x = (DW+1)'(rect_x_max_ff) - (DW+1)'(rect_x_min_ff);
   assign span_y = (DW+1)'(rect_y_max_ff) - (DW+1)'(rect_y_min_ff);
   assign off_x  = DW'(d_ff.x - rxri_pkg::POS_W'(rect_x_min_ff));
   assign off_y  = DW'(d_ff.y - rxri_pkg::POS_W'(rect_y_min_ff));

   always_comb begin
      e_side_in.hit    = d_ff.win
                         && (d_ff.x >= rxri_pkg::POS_W'(rect_x_min_ff))
                         && (d_ff.x <= rxri_pkg::POS_W'(rect_x_max_ff))
                         && (d_ff.y >= rxri_pkg::POS_W'(rect_y_min_ff))
                         && (d_ff.y <= rxri_pkg::POS_W'(rect_y_max_ff));
      e_side_in.ts     = d_ff.ts;
      e_side_in.x      = d_ff.x[DW-1:0];
      e_side_in.y      = d_ff.y[DW-1:0];
      e_side_in.zero_u = (span_x == '0);
      e_side_in.zero_v = (span_y == '0);
      e_side_in.dz_neg = d_ff.dz_neg;
      // quotient stays below 2^TEX_WIDTH, so start with the upper numerator bits loaded
      u_chain[0].rem   = rxri_pkg::REM_W'(off_x[DW-1:1]);
      u_chain[0].div   = span_x[DW:0];
      u_chain[0].nq    = {off_x[0], {(rxri_pkg::NUM_W-1){1'b0}}};
      v_chain[0].rem   = rxri_pkg::REM_W'(off_y[DW-1:1]);
      v_chain[0].div   = span_y[DW:0];
      v_chain[0].nq    = {off_y[0], {(rxri_pkg::NUM_W-1){1'b0}}};
   end

   for (genvar i = 0; i < rxri_pkg::TEX_CELLS; i++) begin : g_tex_cell
      rxri_div_cell u_ucell (
         .clock      (clock),
         .adv        (adv),
         .prev_stage (u_chain[i]),
         .next_stage (u_chain[i+1])
      );
      rxri_div_cell u_vcell (
         .clock      (clock),
         .adv        (adv),
         .prev_stage (v_chain[i]),
         .next_stage (v_chain[i+1])
      );
   end

   logic [rxri_pkg::TEX_CELLS-1:0] e_vld_ff;
   e_side_type                     e_side_ff [rxri_pkg::TEX_CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= '0;
      end else if (adv) begin
         e_vld_ff <= {e_vld_ff[rxri_pkg::TEX_CELLS-2:0], d_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff[0] <= e_side_in;
         for (int i = 1; i < rxri_pkg::TEX_CELLS; i++) begin
            e_side_ff[i] <= e_side_ff[i-1];
         end
      end
   end

   // assemble the result, zero on a miss
   e_side_type        e_last;
   rxri_pkg::rsp_type f_in, f_ff;
   logic              f_vld_ff;

   assign e_last = e_side_ff[rxri_pkg::TEX_CELLS-1];

   always_comb begin
      f_in = '0;
      if (e_last.hit) begin
         f_in.is_hit     = 1'b1;
         f_in.hit_t      = e_last.ts;
         f_in.hit_x      = e_last.x;
         f_in.hit_y      = e_last.y;
         f_in.hit_z      = plane_z_ff;
         f_in.tex_u      = e_last.zero_u ? '0
                           : u_chain[rxri_pkg::TEX_CELLS].nq[rxri_pkg::TEX_WIDTH-1:0];
         f_in.tex_v      = e_last.zero_v ? '0
                           : v_chain[rxri_pkg::TEX_CELLS].nq[rxri_pkg::TEX_WIDTH-1:0];
         f_in.front_face = e_last.dz_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff[rxri_pkg::TEX_CELLS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   rxri_out_skid u_out (
      .clock       (clock),
      .reset       (reset),
      .pipe_valid  (f_vld_ff),
      .pipe_data   (f_ff),
      .pipe_ready  (adv),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/rxri_checker.sv
// rxri_checker: port-level assertions for ray_xy_rectangle_intersect, with its bind.
// Depends on rxri_pkg and the top level's ports.
module rxri_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rxri_pkg::rsp_type rsp_payload
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_hit |-> (rsp_payload == '0))
      else $error("miss with nonzero fields");

   // texture coordinates stay within 0 to 1.0
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_hit |->
         (rsp_payload.tex_u <= rxri_pkg::TEX_WIDTH'(rxri_pkg::FIX_ONE))
         && (rsp_payload.tex_v <= rxri_pkg::TEX_WIDTH'(rxri_pkg::FIX_ONE)))
      else $error("texture coordinate above one");

endmodule

bind ray_xy_rectangle_intersect rxri_checker u_rxri_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: tb/sv/ray_xy_rectangle_intersect_tb.sv
// ray_xy_rectangle_intersect_tb: self-checking bench for the ray / z-plane rectangle intersector.
// Depends on rxri_pkg and ray_xy_rectangle_intersect; predicts each result in Q16.16 and
// compares it with what comes out of the result channel.
`timescale 1ns / 100ps

module ray_xy_rectangle_intersect_tb;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   rxri_pkg::req_type            req_payload;
   logic                         rsp_valid;
   logic                         rsp_ready;
   rxri_pkg::rsp_type            rsp_payload;
   logic                         csr_we;
   logic [rxri_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rxri_pkg::DATA_WIDTH-1:0] csr_wdata;

   // shadow copy of the rectangle registers
   rxri_pkg::word_type rect_x_min, rect_x_max, rect_y_min, rect_y_max, plane_z;
   rxri_pkg::rsp_type  pending_hits[$];
   int                 mismatch_count;
   bit                 calm;

   ray_xy_rectangle_intersect dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint clamp_word(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   function automatic logic [rxri_pkg::TEX_WIDTH-1:0] tex_of(longint pos, longint lo,
                                                            longint hi);
      longint span;
      span = hi - lo;
      if (span <= 0) return '0;
      return rxri_pkg::TEX_WIDTH'(((pos - lo) * 65536) / span);
   endfunction

   // compute the expected result of one ray against the current rectangle
   function automatic rxri_pkg::rsp_type intersect_ray(rxri_pkg::req_type r);
      rxri_pkg::rsp_type h;
      longint  ox, oy, oz, dx, dy, dz, tq, ts, x, y;
      longint  x0, x1, y0, y1, pz;
      h  = '0;
      ox = r.ray_origin_x; oy = r.ray_origin_y; oz = r.ray_origin_z;
      dx = r.ray_dir_x;    dy = r.ray_dir_y;    dz = r.ray_dir_z;
      x0 = rect_x_min; x1 = rect_x_max; y0 = rect_y_min; y1 = rect_y_max; pz = plane_z;
      if (dz == 0) return h;
      tq = ((pz - oz) * 65536) / dz;
      if (tq < longint'(r.t_lower) || tq > longint'(r.t_upper)) return h;
      ts = clamp_word(tq);
      x  = ox + ((dx * ts) >>> 16);
      y  = oy + ((dy * ts) >>> 16);
      if (x < x0 || x > x1 || y < y0 || y > y1) return h;
      h.is_hit     = 1'b1;
      h.hit_t      = rxri_pkg::word_type'(ts);
      h.hit_x      = rxri_pkg::word_type'(clamp_word(x));
      h.hit_y      = rxri_pkg::word_type'(clamp_word(y));
      h.hit_z      = plane_z;
      h.tex_u      = tex_of(x, x0, x1);
      h.tex_v      = tex_of(y, y0, y1);
      h.front_face = (dz < 0);
      return h;
   endfunction

   // randomly hold off the result side, except during the calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 37);
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %h got %h", name, want, got);
      end
   endtask

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rxri_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: expected none got %h", rsp_payload);
         end else begin
            want = pending_hits.pop_front();
            check_field("is_hit", want.is_hit, rsp_payload.is_hit);
            check_field("hit_t", want.hit_t, rsp_payload.hit_t);
            check_field("hit_x", want.hit_x, rsp_payload.hit_x);
            check_field("hit_y", want.hit_y, rsp_payload.hit_y);
            check_field("hit_z", want.hit_z, rsp_payload.hit_z);
            check_field("tex_u", want.tex_u, rsp_payload.tex_u);
            check_field("tex_v", want.tex_v, rsp_payload.tex_v);
            check_field("front_face", want.front_face, rsp_payload.front_face);
         end
      end
   end

   // send one ray and record its prediction at the transfer
   task automatic send_ray(rxri_pkg::req_type r);
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      pending_hits.push_back(intersect_ray(r));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // drive one register write for a cycle; the caller drops the enable afterwards
   task automatic write_csr(rxri_pkg::csr_index_type idx, rxri_pkg::word_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         rxri_pkg::CSR_RECT_X_MIN: rect_x_min = value;
         rxri_pkg::CSR_RECT_X_MAX: rect_x_max = value;
         rxri_pkg::CSR_RECT_Y_MIN: rect_y_min = value;
         rxri_pkg::CSR_RECT_Y_MAX: rect_y_max = value;
         rxri_pkg::CSR_PLANE_Z:    plane_z    = value;
         default: ;
      endcase
   endtask

   task automatic set_rect(rxri_pkg::word_type x0, rxri_pkg::word_type x1,
                           rxri_pkg::word_type y0, rxri_pkg::word_type y1,
                           rxri_pkg::word_type pz);
      wait_drained();
      write_csr(rxri_pkg::CSR_RECT_X_MIN, x0);
      write_csr(rxri_pkg::CSR_RECT_X_MAX, x1);
      write_csr(rxri_pkg::CSR_RECT_Y_MIN, y0);
      write_csr(rxri_pkg::CSR_RECT_Y_MAX, y1);
      write_csr(rxri_pkg::CSR_PLANE_Z, pz);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic rxri_pkg::req_type make_ray(
         rxri_pkg::word_type ox, rxri_pkg::word_type oy, rxri_pkg::word_type oz,
         rxri_pkg::word_type dx, rxri_pkg::word_type dy, rxri_pkg::word_type dz,
         rxri_pkg::word_type tlo, rxri_pkg::word_type thi);
      rxri_pkg::req_type r;
      r.ray_origin_x = ox; r.ray_origin_y = oy; r.ray_origin_z = oz;
      r.ray_dir_x = dx; r.ray_dir_y = dy; r.ray_dir_z = dz;
      r.t_lower = tlo; r.t_upper = thi;
      return r;
   endfunction

   // a ray aimed near the rectangle, usually with a wide window
   function automatic rxri_pkg::req_type aimed_ray();
      rxri_pkg::req_type r;
      longint            span_x, span_y, ox, oy;
      span_x = longint'(rect_x_max) - longint'(rect_x_min);
      span_y = longint'(rect_y_max) - longint'(rect_y_min);
      if (span_x < 0) span_x = 65536;
      if (span_y < 0) span_y = 65536;
      ox = longint'(rect_x_min) + (span_x * $urandom_range(1100)) / 1000 - span_x / 20;
      oy = longint'(rect_y_min) + (span_y * $urandom_range(1100)) / 1000 - span_y / 20;
      r.ray_origin_x = rxri_pkg::word_type'(clamp_word(ox));
      r.ray_origin_y = rxri_pkg::word_type'(clamp_word(oy));
      r.ray_origin_z = rxri_pkg::word_type'(clamp_word(longint'(plane_z)
                          + $signed($urandom_range(262144)) - 131072));
      r.ray_dir_x = rxri_pkg::word_type'($signed($urandom_range(8192)) - 4096);
      r.ray_dir_y = rxri_pkg::word_type'($signed($urandom_range(8192)) - 4096);
      r.ray_dir_z = rxri_pkg::word_type'($signed($urandom_range(131072)) - 65536);
      r.t_lower   = ($urandom_range(3) == 0) ? rxri_pkg::word_type'($urandom_range(200000))
                                             : rxri_pkg::word_type'(32'h8000_0000);
      r.t_upper   = ($urandom_range(3) == 0) ? rxri_pkg::word_type'($urandom_range(400000))
                                             : rxri_pkg::word_type'(32'h7fff_ffff);
      return r;
   endfunction

   function automatic rxri_pkg::req_type noise_ray();
      return make_ray($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
   endfunction

   // default unit square: centered hit, edges, misses, extremes of the fields
   task automatic test_directed();
      rxri_pkg::word_type lo, hi;
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
      send_ray(make_ray(32768, 32768, 65536, 0, 0, -65536, lo, hi));
      send_ray(make_ray(32768, 32768, -65536, 0, 0, 65536, lo, hi));
      send_ray(make_ray(32768, 32768, 65536, 0, 0, 0, lo, hi));
      send_ray(make_ray(0, 0, 65536, 0, 0, -65536, lo, hi));
      send_ray(make_ray(65536, 65536, 65536, 0, 0, -65536, lo, hi));
      send_ray(make_ray(65537, 32768, 65536, 0, 0, -65536, lo, hi));
      send_ray(make_ray(32768, -1, 65536, 0, 0, -65536, lo, hi));
      send_ray(make_ray(32768, 32768, 65536, 0, 0, -65536, 65537, hi));
      send_ray(make_ray(32768, 32768, 65536, 0, 0, -65536, lo, 65535));
      send_ray(make_ray(32768, 32768, 65536, 0, 0, -65536, 65536, 65536));
      send_ray(make_ray(32768, 32768, 65536, 0, 0, -65536, hi, lo));
      send_ray(make_ray(0, 0, 131072, 16384, 16384, -65536, lo, hi));
      send_ray(make_ray(lo, lo, lo, lo, lo, lo, lo, lo));
      send_ray(make_ray(hi, hi, hi, hi, hi, hi, hi, hi));
      send_ray(make_ray(0, 0, hi, 0, 0, 1, lo, hi));
      send_ray(make_ray(0, 0, lo, 0, 0, -1, lo, hi));
      send_ray(make_ray(32768, 32768, 1, 0, 0, lo, lo, hi));
      send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
   endtask

   // zero-width and inverted rectangles
   task automatic test_degenerate();
      set_rect(65536, 65536, 0, 131072, 0);
      send_ray(make_ray(65536, 65536, 65536, 0, 0, -65536, 32'h8000_0000, 32'h7fff_ffff));
      send_ray(make_ray(65536, 131072, 65536, 0, 0, -65536, 32'h8000_0000, 32'h7fff_ffff));
      set_rect(131072, 65536, 0, 65536, 0);
      send_ray(make_ray(98304, 32768, 65536, 0, 0, -65536, 32'h8000_0000, 32'h7fff_ffff));
      set_rect(0, 65536, 0, 0, 0);
      send_ray(make_ray(32768, 0, 65536, 0, 0, -65536, 32'h8000_0000, 32'h7fff_ffff));
   endtask

   task automatic random_phase(int count);
      repeat (count) begin
         if ($urandom_range(9) < 8) send_ray(aimed_ray());
         else send_ray(noise_ray());
      end
   endtask

   // several rectangle settings, extremes among them, with random rays
   task automatic test_random();
      set_rect(0, 65536, 0, 65536, 0);
      random_phase(180);
      set_rect(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      random_phase(150);
      set_rect(-262144, 393216, -131072, 65536, -655360);
      calm = 1'b1;
      random_phase(200);
      calm = 1'b0;
      // let every prediction arrive before the sender resumes
      wait_drained();
      random_phase(150);
      set_rect($urandom, $urandom, $urandom, $urandom, 32'h8000_0000);
      random_phase(120);
      repeat (4) begin
         set_rect(rxri_pkg::word_type'(-$urandom_range(1 << 20)),
                  rxri_pkg::word_type'($urandom_range(1 << 20)),
                  rxri_pkg::word_type'(-$urandom_range(1 << 20)),
                  rxri_pkg::word_type'($urandom_range(1 << 20)),
                  $urandom);
         random_phase(75);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      mismatch_count = 0;
      rect_x_min = 0; rect_x_max = 65536; rect_y_min = 0; rect_y_max = 65536; plane_z = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_degenerate();
      test_random();
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_hits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/rxri_pkg.sv
sv/rxri_div_cell.sv
sv/rxri_out_skid.sv
sv/ray_xy_rectangle_intersect.sv
sv/rxri_checker.sv
tb/sv/ray_xy_rectangle_intersect_tb.sv
